@@ rtl/lfr_pkg.sv @@
`default_nettype none

package lfr_pkg;

   localparam int NumLetters    = 26;
   localparam int LetterIdxW    = $clog2(NumLetters);
   localparam int CountWidth    = 16;
   localparam int OutCountWidth = 16;
   localparam int CodeWidth     = 7;
   localparam int WideW         = (CountWidth > OutCountWidth) ? CountWidth : OutCountWidth;

   localparam logic [7:0] CaseBit  = 8'd32;
   localparam logic [7:0] LowerA   = 8'h61;
   localparam logic [7:0] LowerZ   = 8'h7a;
   localparam logic [LetterIdxW-1:0] LastLetter = LetterIdxW'(NumLetters - 1);

   localparam logic [CountWidth-1:0]    CountMax    = '1;
   localparam logic [OutCountWidth-1:0] OutCountMax = '1;

   // one access to the counter memory
   typedef struct packed {
      logic                  rd_en;
      logic [LetterIdxW-1:0] rd_addr;
      logic                  wr_en;
      logic [LetterIdxW-1:0] wr_addr;
      logic [CountWidth-1:0] wr_data;
      logic                  clear;
   } mem_req_type;

   typedef struct packed {
      logic                  is_letter;
      logic [LetterIdxW-1:0] idx;
   } letter_type;

   // folding case sets bit 5, which maps 'A'..'Z' onto 'a'..'z'
   function automatic letter_type letter_decode(input logic [7:0] b);
      letter_type r;
      logic [7:0] low;
      low = b | CaseBit;
      r.is_letter = (low >= LowerA) && (low <= LowerZ);
      r.idx = LetterIdxW'(low - LowerA);
      return r;
   endfunction

   function automatic logic [OutCountWidth-1:0] clip_count(input logic [CountWidth-1:0] c);
      logic [WideW-1:0] w;
      w = WideW'(c);
      if (w > WideW'(OutCountMax)) begin
         w = WideW'(OutCountMax);
      end
      return OutCountWidth'(w);
   endfunction

   function automatic logic [CodeWidth-1:0] letter_code_of(input logic [LetterIdxW-1:0] idx);
      return CodeWidth'(LowerA + 8'(idx));
   endfunction

endpackage

`default_nettype wire

@@ rtl/lfr_count_mem.sv @@
`default_nettype none

module lfr_count_mem (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lfr_pkg::mem_req_type           req,
   output logic [lfr_pkg::CountWidth-1:0]      rd_data
);
   import lfr_pkg::*;

   logic [CountWidth-1:0] mem [NumLetters];
   logic [NumLetters-1:0] valid_ff;
   logic [NumLetters-1:0] valid_in;
   logic [CountWidth-1:0] rd_raw_ff;
   logic                  rd_live_ff;

   // entries never written since the last clear read as zero
   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_raw_ff  <= mem[req.rd_addr];
         rd_live_ff <= valid_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_live_ff ? rd_raw_ff : '0;

endmodule

`default_nettype wire

@@ rtl/letter_frequency_rank_unit.sv @@
`default_nettype none

// letter histogram with ranked dump. text arrives one byte per word on the req
// channel; letters are counted case-insensitively in 26 saturating counters held
// in a small synchronous memory, other bytes are ignored. counting runs at one
// byte per cycle: a read-increment-write pipeline with forwarding between
// back-to-back hits on the same letter. the byte flagged by req_tlast is counted,
// then req_tready drops and the block dumps 26 words on rsp, highest count first,
// ties in alphabetical order, rsp_tlast on the final one; the counters are then
// cleared at once and req_tready returns. each ranked word costs a full scan of
// the counter memory through its single read port, and a stall on rsp holds the
// dump in place until rsp_tready rises.
module letter_frequency_rank_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [6:0] letter_code, [22:7] letter_count, [23] zero
   output logic             rsp_tlast    // last_of_run
);
   import lfr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,   // counting text
      ST_WAIT  = 5'b00010,   // final byte's write back
      ST_SCAN  = 5'b00100,   // reading counters for the next rank
      ST_LAST  = 5'b01000,   // compare of the last counter
      ST_EMIT  = 5'b10000    // hand the winner to the output register
   } state_type;

   state_type state_ff, state_in;

   mem_req_type           mem_req;
   logic [CountWidth-1:0] rd_data;

   // counting pipeline
   letter_type            dec;
   logic                  req_acc;
   logic                  s1_vld_ff, s1_vld_in;
   logic [LetterIdxW-1:0] s1_idx_ff, s1_idx_in;
   logic                  fwd_vld_ff, fwd_vld_in;
   logic [LetterIdxW-1:0] fwd_idx_ff, fwd_idx_in;
   logic [CountWidth-1:0] fwd_data_ff, fwd_data_in;
   logic [CountWidth-1:0] cur_cnt;
   logic [CountWidth-1:0] new_cnt;

   // ranking scan
   logic [LetterIdxW-1:0] scan_addr_ff, scan_addr_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [LetterIdxW-1:0] cmp_idx_ff, cmp_idx_in;
   logic                  best_found_ff, best_found_in;
   logic [LetterIdxW-1:0] best_idx_ff, best_idx_in;
   logic [CountWidth-1:0] best_cnt_ff, best_cnt_in;
   logic [NumLetters-1:0] emitted_ff, emitted_in;
   logic [LetterIdxW-1:0] rank_ff, rank_in;
   logic                  take;
   logic                  scan_rd;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [23:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  out_free;
   logic                  load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign dec        = letter_decode(req_tdata);
   assign scan_rd    = (state_ff == ST_SCAN);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load       = (state_ff == ST_EMIT) && out_free;

   // a hit on the letter written last cycle reads stale data: take the forwarded value
   always_comb begin
      cur_cnt = (fwd_vld_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_data_ff : rd_data;
      new_cnt = (cur_cnt == CountMax) ? cur_cnt : cur_cnt + 1'b1;
   end

   always_comb begin
      mem_req.rd_en   = (req_acc && dec.is_letter) || scan_rd;
      mem_req.rd_addr = scan_rd ? scan_addr_ff : dec.idx;
      mem_req.wr_en   = s1_vld_ff;
      mem_req.wr_addr = s1_idx_ff;
      mem_req.wr_data = new_cnt;
      mem_req.clear   = load && (rank_ff == LastLetter);
   end

   lfr_count_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_vld_in   = req_acc && dec.is_letter;
      s1_idx_in   = dec.idx;
      fwd_vld_in  = s1_vld_ff;
      fwd_idx_in  = s1_idx_ff;
      fwd_data_in = new_cnt;
   end

   // strict greater-than over an ascending scan keeps ties alphabetical
   assign take = cmp_vld_ff && !emitted_ff[cmp_idx_ff]
                 && (!best_found_ff || (rd_data > best_cnt_ff));

   always_comb begin
      state_in      = state_ff;
      scan_addr_in  = scan_addr_ff;
      cmp_vld_in    = scan_rd;
      cmp_idx_in    = scan_addr_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_cnt_in   = best_cnt_ff;
      emitted_in    = emitted_ff;
      rank_in       = rank_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      if (take) begin
         best_found_in = 1'b1;
         best_idx_in   = cmp_idx_ff;
         best_cnt_in   = rd_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tlast) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in      = ST_SCAN;
            scan_addr_in  = '0;
            best_found_in = 1'b0;
         end
         ST_SCAN: begin
            if (scan_addr_ff == LastLetter) begin
               state_in = ST_LAST;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {1'b0, clip_count(best_cnt_ff), letter_code_of(best_idx_ff)};
               rsp_last_in   = (rank_ff == LastLetter);
               best_found_in = 1'b0;
               scan_addr_in  = '0;
               if (rank_ff == LastLetter) begin
                  state_in   = ST_IDLE;
                  rank_in    = '0;
                  emitted_in = '0;
               end else begin
                  state_in   = ST_SCAN;
                  rank_in    = rank_ff + 1'b1;
                  emitted_in[best_idx_ff] = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         s1_vld_ff     <= 1'b0;
         fwd_vld_ff    <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         emitted_ff    <= '0;
         rank_ff       <= '0;
         scan_addr_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         s1_vld_ff     <= s1_vld_in;
         fwd_vld_ff    <= fwd_vld_in;
         cmp_vld_ff    <= cmp_vld_in;
         best_found_ff <= best_found_in;
         emitted_ff    <= emitted_in;
         rank_ff       <= rank_in;
         scan_addr_ff  <= scan_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff   <= s1_idx_in;
      fwd_idx_ff  <= fwd_idx_in;
      fwd_data_ff <= fwd_data_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_cnt_ff <= best_cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // no counter write may be in flight while the scan reads the memory
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !s1_vld_ff)
      else $error("counter write during rank scan");

   // a winner always exists when a word is handed out
   a_best_at_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> best_found_ff)
      else $error("emit without a selected letter");

   // one letter is retired per emitted rank
   a_rank_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(emitted_ff) == int'(rank_ff))
      else $error("emitted set out of step with rank");

   // the run's final word leaves the block back in counting mode with fresh ranks
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> ((emitted_ff == '0) && (rank_ff == '0)))
      else $error("rank state not cleared after final word");

endmodule

`default_nettype wire
